### rtl/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack package
// Shared widths, operation and status codes, controller states and the
// memory control group used by the segmented stack modules.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 10;
  localparam int PPS_W  = 11;
  // Widest flat position: stack index times capacity plus element index.
  localparam int POS_W  = IDX_W + PPS_W;

  localparam logic [PPS_W-1:0] PPS_RESET = PPS_W'(8);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_POP_AT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_PICK,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### rtl/ssr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack channels
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface ssr_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssr_pkg::MODE_W-1:0]   mode;
  logic signed [ssr_pkg::DATA_W-1:0] push_value;
  logic [ssr_pkg::IDX_W-1:0]    stack_index;
  logic [ssr_pkg::IDX_W-1:0]    element_index;

  modport source (output valid, mode, push_value, stack_index, element_index,
                  input ready);
  modport sink   (input valid, mode, push_value, stack_index, element_index,
                  output ready);
endinterface

interface ssr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssr_pkg::DATA_W-1:0] popped_value;
  ssr_pkg::status_t                  status;

  modport source (output valid, popped_value, status, input ready);
  modport sink   (input valid, popped_value, status, output ready);
endinterface

### rtl/ssr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack entry memory
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module ssr_mem #(
  parameter int DEPTH = ssr_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(ssr_pkg::DEPTH_DEF)
) (
  input  logic                       clk,
  input  ssr_pkg::mem_ctl_t          mem_ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [ssr_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [ssr_pkg::DATA_W-1:0] rdata
);
  import ssr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ssr_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack position unit
// Holds the sub-stack capacity and turns a sub-stack number and element
// index into a flat position, with its validity check.
// ----------------------------------------------------------------------------
module ssr_pos #(
  parameter int AW = $clog2(ssr_pkg::DEPTH_DEF),
  parameter int CW = $clog2(ssr_pkg::DEPTH_DEF + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ssr_pkg::PPS_W-1:0] cfg_wdata,
  input  logic                      load,
  input  logic [ssr_pkg::IDX_W-1:0] stack_index,
  input  logic [ssr_pkg::IDX_W-1:0] element_index,
  input  logic [CW-1:0]             count,
  output logic                      pos_ok,
  output logic [AW-1:0]             pos
);
  import ssr_pkg::*;

  logic [PPS_W-1:0] pps_r;
  logic [POS_W-1:0] prod_r;
  logic [IDX_W-1:0] eidx_r;
  logic             elem_ok_r;
  logic [POS_W-1:0] prod_nxt;
  logic [POS_W-1:0] pos_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pps_r <= PPS_RESET;
    end else if (cfg_we) begin
      pps_r <= cfg_wdata;
    end
  end

  assign prod_nxt = POS_W'(stack_index) * POS_W'(pps_r);

  // The product is registered on the accepting edge; the add and bound
  // check follow in the decode cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r    <= prod_nxt;
      eidx_r    <= element_index;
      elem_ok_r <= {1'b0, element_index} < pps_r;
    end
  end

  assign pos_full = prod_r + POS_W'(eidx_r);
  assign pos_ok   = elem_ok_r && (pos_full < POS_W'(count));
  assign pos      = pos_full[AW-1:0];

endmodule

### rtl/ssr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack controller
// Sequences push, pop and pop-at against the entry memory, keeps the entry
// count and holds the result register.
// ----------------------------------------------------------------------------
module ssr_ctrl #(
  parameter int DEPTH = ssr_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(ssr_pkg::DEPTH_DEF),
  parameter int CW    = $clog2(ssr_pkg::DEPTH_DEF + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ssr_in_if.sink                     in_bus,
  ssr_out_if.source                  out_bus,
  input  logic                       pos_ok,
  input  logic [AW-1:0]              pos,
  output logic [CW-1:0]              count,
  output ssr_pkg::mem_ctl_t          mem_ctl,
  output logic [AW-1:0]              waddr,
  output logic [ssr_pkg::DATA_W-1:0] wdata,
  output logic [AW-1:0]              raddr,
  input  logic [ssr_pkg::DATA_W-1:0] rdata
);
  import ssr_pkg::*;

  state_t            state_r, state_nxt;
  mode_t             mode_r;
  logic [DATA_W-1:0] value_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  status_t           out_st_r, out_st_nxt;

  logic              accept;
  logic              out_free;
  logic              fin;
  logic [DATA_W-1:0] fin_val;
  status_t           fin_st;
  logic [CW:0]       dst_ext;
  logic [CW:0]       count_ext;
  logic              more_pick;
  logic              more_shift;
  state_t            fin_state;

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  assign dst_ext    = {{(CW + 1 - AW){1'b0}}, dst_r};
  assign count_ext  = {1'b0, count_r};
  assign more_pick  = (dst_ext + (CW + 1)'(1)) < count_ext;
  assign more_shift = (dst_ext + (CW + 1)'(2)) < count_ext;
  assign fin_state  = out_free ? S_IDLE : S_DONE;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (mode_r == MODE_POP && count_r != '0) begin
          state_nxt = S_POP_RD;
        end else if (mode_r == MODE_POP_AT && pos_ok) begin
          state_nxt = S_PICK;
        end else begin
          state_nxt = fin_state;
        end
      end
      S_POP_RD: state_nxt = fin_state;
      S_PICK: begin
        state_nxt = more_pick ? S_SHIFT : fin_state;
      end
      S_SHIFT: begin
        if (!more_shift) state_nxt = fin_state;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    fin         = 1'b0;
    fin_val     = '0;
    fin_st      = STAT_OK;
    count_nxt   = count_r;
    dst_nxt     = dst_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    mem_ctl     = '0;
    waddr       = dst_r;
    wdata       = rdata;
    raddr       = dst_r;
    case (state_r)
      S_DECODE: begin
        case (mode_r)
          MODE_PUSH: begin
            fin = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              fin_st = STAT_FULL;
            end else begin
              mem_ctl.we = 1'b1;
              waddr      = count_r[AW-1:0];
              wdata      = value_r;
              count_nxt  = count_r + 1'b1;
            end
          end
          MODE_POP: begin
            if (count_r == '0) begin
              fin    = 1'b1;
              fin_st = STAT_EMPTY;
            end else begin
              mem_ctl.re = 1'b1;
              raddr      = AW'(count_r - 1'b1);
              count_nxt  = count_r - 1'b1;
            end
          end
          MODE_POP_AT: begin
            if (pos_ok) begin
              mem_ctl.re = 1'b1;
              raddr      = pos;
              dst_nxt    = pos;
            end else begin
              fin    = 1'b1;
              fin_st = STAT_INVALID;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = STAT_INVALID;
          end
        endcase
      end
      S_POP_RD: begin
        fin     = 1'b1;
        fin_val = rdata;
      end
      S_PICK: begin
        res_val_nxt = rdata;
        if (more_pick) begin
          mem_ctl.re = 1'b1;
          raddr      = dst_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          fin       = 1'b1;
          fin_val   = rdata;
        end
      end
      S_SHIFT: begin
        // Entry dst+1 arrives from the memory and moves down to dst while
        // the next one up is read.
        mem_ctl.we = 1'b1;
        waddr      = dst_r;
        wdata      = rdata;
        dst_nxt    = dst_r + 1'b1;
        if (more_shift) begin
          mem_ctl.re = 1'b1;
          raddr      = dst_r + AW'(2);
        end else begin
          count_nxt = count_r - 1'b1;
          fin       = 1'b1;
          fin_val   = res_val_r;
        end
      end
      S_DONE: begin
        fin     = 1'b1;
        fin_val = res_val_r;
        fin_st  = res_st_r;
      end
      default: begin
      end
    endcase

    if (fin && !out_free) begin
      res_val_nxt = fin_val;
      res_st_nxt  = fin_st;
    end
  end

  always_comb begin
    out_val_nxt = out_val_r;
    out_st_nxt  = out_st_r;
    if (fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = fin_val;
      out_st_nxt    = fin_st;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= mode_t'(in_bus.mode);
      value_r <= in_bus.push_value;
    end
    dst_r     <= dst_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.popped_value = out_val_r;
  assign out_bus.status       = out_st_r;
  assign count                = count_r;

endmodule

### rtl/segmented_stack_with_remove_at_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack with remove-at
// A set of fixed-capacity sub-stacks kept packed in one flat memory with an
// entry count; supports push, pop and removal from any position.
//
//   Port      Dir   Beat contents
//   in_bus    sink  mode, push_value, stack_index, element_index
//   out_bus   src   popped_value, status
//   cfg_*     in    plates_per_stack (write only)
//
// Push, pop on an empty stack and refused requests finish in the decode state;
// pop adds a read state, and pop-at moves each entry above the removed one down
// one place through the single memory read port and write port. A stalled
// result holds the block in its done state. Reset clears the count and the
// result valid flag; the memory is not cleared. A new beat is taken while a
// finished result still waits in the output register.
// ----------------------------------------------------------------------------
module segmented_stack_with_remove_at_unit #(
  parameter int TOTAL_DEPTH = ssr_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ssr_pkg::PPS_W-1:0] cfg_wdata,
  ssr_in_if.sink                    in_bus,
  ssr_out_if.source                 out_bus
);
  import ssr_pkg::*;

  localparam int AW = $clog2(TOTAL_DEPTH);
  localparam int CW = $clog2(TOTAL_DEPTH + 1);

  logic              pos_ok;
  logic [AW-1:0]     pos;
  logic [CW-1:0]     count;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic [CW:0]       count_ext;

  ssr_pos #(
    .AW (AW),
    .CW (CW)
  ) u_pos (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .load          (in_bus.valid && in_bus.ready),
    .stack_index   (in_bus.stack_index),
    .element_index (in_bus.element_index),
    .count         (count),
    .pos_ok        (pos_ok),
    .pos           (pos)
  );

  ssr_mem #(
    .DEPTH (TOTAL_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  ssr_ctrl #(
    .DEPTH (TOTAL_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .pos_ok  (pos_ok),
    .pos     (pos),
    .count   (count),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  assign count_ext = {1'b0, count};

  // Failed requests never carry a value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status != STAT_OK |-> out_bus.popped_value == '0)
    else $error("nonzero value on a failed result");

  // One request at a time: no beat is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> !in_bus.ready)
    else $error("beat accepted while a request is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_ext <= (CW + 1)'(TOTAL_DEPTH))
    else $error("entry count above capacity");

  // The count moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_ext == $past(count_ext) ||
         count_ext == $past(count_ext) + (CW + 1)'(1) ||
         count_ext + (CW + 1)'(1) == $past(count_ext)))
    else $error("entry count jumped");

endmodule

### tb/segmented_stack_with_remove_at_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack checker
// Watches the operation, result and capacity ports of the segmented stack.
// Keeps a shadow copy of the flat store, the fill level and the capacity, and
// works out the result of every accepted operation beat. Each accepted result
// beat is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module segmented_stack_with_remove_at_unit_checker #(
  parameter int DEPTH = ssr_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ssr_pkg::PPS_W-1:0] cfg_wdata,
  ssr_in_if                         in_mon,
  ssr_out_if                        out_mon,
  output int                        err_count,
  output int                        pending,
  output int                        checked
);
  import ssr_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } pop_result_t;

  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int unsigned              shadow_level;
  logic [PPS_W-1:0]         shadow_pps;
  pop_result_t              due_results [$];
  int                       mismatches = 0;
  int                       seen = 0;

  // Applies one operation to the shadow stack and returns what the block owes.
  function automatic pop_result_t predict_pop_result(input logic [MODE_W-1:0] op,
                                                     input logic [DATA_W-1:0] val,
                                                     input logic [IDX_W-1:0]  sidx,
                                                     input logic [IDX_W-1:0]  eidx);
    pop_result_t r;
    int unsigned pos;
    r.value  = '0;
    r.status = STAT_INVALID;
    case (op)
      MODE_PUSH: begin
        if (shadow_level >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_mem[shadow_level] = val;
          shadow_level++;
          r.status = STAT_OK;
        end
      end
      MODE_POP: begin
        if (shadow_level == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          shadow_level--;
          r.value  = shadow_mem[shadow_level];
          r.status = STAT_OK;
        end
      end
      MODE_POP_AT: begin
        pos = 32'(sidx) * 32'(shadow_pps) + 32'(eidx);
        if (32'(eidx) < 32'(shadow_pps) && pos < shadow_level) begin
          r.value = shadow_mem[pos];
          // Later entries close the gap so every sub-stack below the top stays full.
          for (int unsigned i = pos; i + 1 < shadow_level; i++)
            shadow_mem[i] = shadow_mem[i + 1];
          shadow_level--;
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pop_result_t want;
    if (!rst_n) begin
      shadow_level = 0;
      shadow_pps   = PPS_RESET;
      due_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing outstanding: value %0d status %0d",
                   $time, out_mon.popped_value, out_mon.status);
        end else begin
          want = due_results.pop_front();
          if (want.value !== out_mon.popped_value || want.status !== out_mon.status) begin
            mismatches++;
            $display("%0t: mismatch: expected value %0d status %0d, got value %0d status %0d",
                     $time, want.value, want.status, out_mon.popped_value, out_mon.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_results.insert(due_results.size(),
                           predict_pop_result(in_mon.mode, in_mon.push_value,
                                              in_mon.stack_index, in_mon.element_index));
      if (cfg_we)
        shadow_pps = cfg_wdata;
    end
    err_count <= mismatches;
    pending   <= due_results.size();
    checked   <= seen;
  end

endmodule

### tb/segmented_stack_with_remove_at_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented stack testbench
// Drives push, pop, pop-at and unused-mode beats into the segmented stack
// under several sub-stack capacities, with bursty input and a stalling
// receiver. A directed opening covers the corner cases, random phases follow,
// and a final phase gathers the entries into one sub-stack and drains it.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module segmented_stack_with_remove_at_unit_tb;
  import ssr_pkg::*;

  localparam int                DEPTH       = DEPTH_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [PPS_W-1:0] cfg_wdata;
  int               chk_errors;
  int               chk_pending;
  int               chk_checked;

  ssr_in_if  in_bus ();
  ssr_out_if out_bus ();

  // Stimulus-side bookkeeping; the fill level only steers which beats are sent.
  int burst_left;
  int stack_level;
  int capacity;
  int hold_req;
  int cap_writes;
  int beats_by_mode [4];

  segmented_stack_with_remove_at_unit #(
    .TOTAL_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  segmented_stack_with_remove_at_unit_checker #(
    .DEPTH(DEPTH)
  ) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_mon   (in_bus),
    .out_mon  (out_bus),
    .err_count(chk_errors),
    .pending  (chk_pending),
    .checked  (chk_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("segmented_stack_with_remove_at_unit_tb: done, errors");
    $finish;
  end

  // Result side: stall styles change every so often, and a requested hold-off
  // keeps ready low for a counted stretch so the block backs up.
  initial begin : rx_pattern
    int hold_left;
    int style;
    int style_left;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (style)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_op(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] val,
                         input logic [IDX_W-1:0] sidx, input logic [IDX_W-1:0] eidx);
    int          gap;
    int unsigned pos;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= op;
    in_bus.push_value    <= val;
    in_bus.stack_index   <= sidx;
    in_bus.element_index <= eidx;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    burst_left--;
    beats_by_mode[op]++;
    pos = 32'(sidx) * 32'(capacity) + 32'(eidx);
    case (op)
      MODE_PUSH:   if (stack_level < DEPTH) stack_level++;
      MODE_POP:    if (stack_level > 0) stack_level--;
      MODE_POP_AT: if (32'(eidx) < 32'(capacity) && pos < stack_level) stack_level--;
      default: ;
    endcase
  endtask

  // Stops offering beats and waits until every predicted result has come back.
  task automatic drain_results(input int settle);
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [PPS_W-1:0] cap);
    drain_results(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = cap;
    cap_writes++;
  endtask

  // Mostly well-formed traffic around a target fill level, with some noise.
  task automatic random_op(input int target);
    int               pick;
    int unsigned      pos;
    logic [IDX_W-1:0] sidx;
    logic [IDX_W-1:0] eidx;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: send_op(MODE_UNUSED, $urandom, IDX_W'($urandom), IDX_W'($urandom));
        1: send_op(MODE_POP_AT, $urandom, IDX_W'($urandom), IDX_W'($urandom));
        2: begin
          // One place past the top entry.
          if (capacity != 0) begin
            sidx = IDX_W'(stack_level / capacity);
            eidx = IDX_W'(stack_level % capacity);
          end else begin
            sidx = '0;
            eidx = '0;
          end
          send_op(MODE_POP_AT, $urandom, sidx, eidx);
        end
        default: begin
          eidx = (capacity < 1020) ? IDX_W'(capacity + $urandom_range(0, 3))
                                   : IDX_W'($urandom);
          send_op(MODE_POP_AT, $urandom, IDX_W'($urandom_range(0, 3)), eidx);
        end
      endcase
    end else if (pick < ((stack_level < target) ? 60 : 35)) begin
      send_op(MODE_PUSH, $urandom, IDX_W'($urandom), IDX_W'($urandom));
    end else if (pick < ((stack_level < target) ? 72 : 62) || stack_level == 0 ||
                 capacity == 0) begin
      send_op(MODE_POP, $urandom, IDX_W'($urandom), IDX_W'($urandom));
    end else begin
      pos = $urandom_range(0, stack_level - 1);
      send_op(MODE_POP_AT, $urandom, IDX_W'(pos / capacity), IDX_W'(pos % capacity));
    end
  endtask

  initial begin : stimulus
    int caps [9];
    int target;
    int unsigned pos;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.mode          <= MODE_PUSH;
    in_bus.push_value    <= '0;
    in_bus.stack_index   <= '0;
    in_bus.element_index <= '0;
    burst_left  = 0;
    stack_level = 0;
    capacity    = PPS_RESET;
    hold_req    = 0;
    cap_writes  = 0;
    beats_by_mode = '{0, 0, 0, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset capacity of eight.
    send_op(MODE_POP, '0, '0, '0);
    send_op(MODE_POP_AT, '0, '0, '0);
    send_op(MODE_UNUSED, '0, '0, '0);
    send_op(MODE_PUSH, 32'h7FFF_FFFF, '0, '0);
    send_op(MODE_PUSH, 32'h8000_0000, '0, '0);
    send_op(MODE_PUSH, 32'h0000_0000, '1, '1);
    send_op(MODE_PUSH, 32'hFFFF_FFFF, '0, '0);
    send_op(MODE_PUSH, 32'hAAAA_AAAA, '0, '0);
    send_op(MODE_PUSH, 32'h5555_5555, '0, '0);
    send_op(MODE_PUSH, 32'd1, '0, '0);
    send_op(MODE_PUSH, 32'd2, '0, '0);
    send_op(MODE_PUSH, 32'd3, '0, '0);
    send_op(MODE_PUSH, 32'd4, '0, '0);
    send_op(MODE_POP_AT, '0, 10'd0, 10'd8);
    send_op(MODE_POP_AT, '0, 10'd1, 10'd2);
    send_op(MODE_POP_AT, '0, '1, '1);
    send_op(MODE_POP_AT, '0, 10'd1, 10'd1);
    send_op(MODE_POP_AT, '0, 10'd0, 10'd0);
    send_op(MODE_POP, '0, '0, '0);
    send_op(MODE_UNUSED, '1, '1, '1);
    // With no capacity every pop-at is refused, while push and pop still work.
    set_capacity('0);
    send_op(MODE_POP_AT, '0, '0, '0);
    send_op(MODE_PUSH, 32'h1234_5678, '0, '0);
    send_op(MODE_POP, '0, '0, '0);

    caps = '{1, 3, DEPTH, 8, 0, 2, 0, 1023, 0};
    caps[4] = $urandom_range(1, DEPTH);
    caps[8] = $urandom_range(1, DEPTH);
    foreach (caps[p]) begin
      set_capacity(PPS_W'(caps[p]));
      target = $urandom_range(2, 40);
      if (p == 0) hold_req = 300;
      repeat (55) random_op(target);
    end

    // One sub-stack holds everything: build it up, reach the top, step past
    // it, then take the bottom entry so the whole store moves down.
    set_capacity(PPS_W'(DEPTH));
    while (stack_level < 48) send_op(MODE_PUSH, $urandom, '0, '0);
    send_op(MODE_POP_AT, '0, '0, IDX_W'(stack_level - 1));
    send_op(MODE_POP_AT, '0, 10'd1, '0);
    send_op(MODE_POP_AT, '0, '0, IDX_W'(stack_level));
    send_op(MODE_POP_AT, '0, '0, '0);
    while (stack_level > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        pos = $urandom_range(0, stack_level - 1);
        send_op(MODE_POP_AT, '0, '0, IDX_W'(pos));
      end else begin
        send_op(MODE_POP, '0, '0, '0);
      end
    end
    send_op(MODE_POP, '0, '0, '0);

    drain_results(20);
    $display("covered %0d push, %0d pop, %0d pop-at, %0d unused-mode beats, %0d cap writes",
             beats_by_mode[MODE_PUSH], beats_by_mode[MODE_POP], beats_by_mode[MODE_POP_AT],
             beats_by_mode[MODE_UNUSED], cap_writes);
    $display("compared %0d result beats, %0d mismatches", chk_checked, chk_errors);
    if (chk_errors == 0) begin
      $display("segmented_stack_with_remove_at_unit_tb: done, clean");
    end else begin
      $display("segmented_stack_with_remove_at_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
